### hw/rtl/shrm_pkg.sv
// Shared types, constants and helpers for the sample history ring with min/max.
package shrm_pkg;

  // Store geometry and sample width
  localparam int DEPTH       = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int SAMP_W      = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channels
  localparam int REQ_W = 2;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;

  // Queue depths between the parts
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Extremes after a clear
  localparam logic signed [SAMP_W-1:0] SAMP_MAX_POS = {1'b0, {(SAMP_W - 1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] SAMP_MAX_NEG = {1'b1, {(SAMP_W - 1){1'b0}}};

  // Request codes as they arrive on the input channel
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SNAP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_SNAP,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_SNAP
  } back_state_t;

  // Input item
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] sample_value;
    logic [CNT_W-1:0]        count_or_age;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic                    has_sample;
    logic                    is_last;
    logic signed [VAL_W-1:0] running_min;
    logic signed [VAL_W-1:0] running_max;
    logic [CNT_W-1:0]        fill_count;
  } out_item_t;

  // Decoded command handed from the front to the back
  typedef struct packed {
    op_t                      op;
    logic signed [SAMP_W-1:0] sample;
    logic [FILL_W-1:0]        cnt;     // clipped snapshot length or effective age
    logic                     age_ok;  // age within the store depth
  } cmd_t;

endpackage

### hw/rtl/shrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/shrm_front.sv
// Front part: accepts input transactions, decodes them and queues commands.
module shrm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  shrm_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output shrm_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  shrm_pkg::cmd_t                     cq_r [shrm_pkg::CQ_DEPTH];
  logic [shrm_pkg::CQ_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [shrm_pkg::CQ_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [shrm_pkg::CQ_CNT_W-1:0]      count_r, count_nxt;
  shrm_pkg::cmd_t                     dec;
  logic [shrm_pkg::FILL_W-1:0]        cnt_clip;
  logic                               acc;
  logic                               take;

  // Decode the request and clip the count to the store depth
  always_comb begin
    if (in_data.count_or_age > shrm_pkg::CNT_W'(shrm_pkg::DEPTH)) begin
      cnt_clip = shrm_pkg::FILL_W'(shrm_pkg::DEPTH);
    end else begin
      cnt_clip = in_data.count_or_age[shrm_pkg::FILL_W-1:0];
    end
    dec.sample = in_data.sample_value[shrm_pkg::SAMP_W-1:0];
    dec.cnt    = cnt_clip;
    dec.age_ok = (in_data.count_or_age <= shrm_pkg::CNT_W'(shrm_pkg::DEPTH));
    unique case (in_data.req_type)
      shrm_pkg::REQ_APPEND: dec.op = shrm_pkg::OP_APPEND;
      shrm_pkg::REQ_SNAP:   dec.op = shrm_pkg::OP_SNAP;
      shrm_pkg::REQ_READ: begin
        dec.op = shrm_pkg::OP_READ;
        // age zero addresses the oldest slot of a full store
        if (in_data.count_or_age == '0) begin
          dec.cnt = shrm_pkg::FILL_W'(shrm_pkg::DEPTH);
        end
      end
      default:              dec.op = shrm_pkg::OP_CLEAR;
    endcase
  end

  assign in_full   = (count_r == shrm_pkg::CQ_CNT_W'(shrm_pkg::CQ_DEPTH));
  assign acc       = in_push && !in_full;
  assign cmd_valid = (count_r != '0);
  assign take      = cmd_take && cmd_valid;
  assign cmd       = cq_r[rd_ptr_r];

  // Advance queue pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (acc) begin
      wr_ptr_nxt = (wr_ptr_r == shrm_pkg::CQ_PTR_W'(shrm_pkg::CQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == shrm_pkg::CQ_PTR_W'(shrm_pkg::CQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (acc && !take) begin
      count_nxt = count_r + 1'b1;
    end else if (take && !acc) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (acc) begin
      cq_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### hw/rtl/shrm_out_fifo.sv
// Result queue between the back part and the result channel.
module shrm_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_push,
  input  shrm_pkg::out_item_t           res_data,
  output logic [shrm_pkg::OQ_CNT_W-1:0] oq_count,
  output logic                          out_empty,
  input  logic                          out_pop,
  output shrm_pkg::out_item_t           out_data
);

  shrm_pkg::out_item_t                oq_r [shrm_pkg::OQ_DEPTH];
  logic [shrm_pkg::OQ_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [shrm_pkg::OQ_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [shrm_pkg::OQ_CNT_W-1:0]      count_r, count_nxt;
  logic                               pop;

  assign out_empty = (count_r == '0);
  assign pop       = out_pop && !out_empty;
  assign out_data  = oq_r[rd_ptr_r];
  assign oq_count  = count_r;

  // Advance pointers; the back part only pushes when there is room
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (res_push) begin
      wr_ptr_nxt = (wr_ptr_r == shrm_pkg::OQ_PTR_W'(shrm_pkg::OQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == shrm_pkg::OQ_PTR_W'(shrm_pkg::OQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (res_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !res_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued results
  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[wr_ptr_r] <= res_data;
    end
  end

endmodule

### hw/rtl/shrm_back.sv
// Back part: executes commands against the sample store and running extremes.
module shrm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  shrm_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  logic [shrm_pkg::OQ_CNT_W-1:0] oq_count,
  output logic                          res_push,
  output shrm_pkg::out_item_t           res_data
);

  shrm_pkg::back_state_t              state_r, state_nxt;
  logic [shrm_pkg::PTR_W-1:0]         wp_r, wp_nxt;
  logic                               full_r, full_nxt;
  logic signed [shrm_pkg::SAMP_W-1:0] min_r, min_nxt;
  logic signed [shrm_pkg::SAMP_W-1:0] max_r, max_nxt;
  logic [shrm_pkg::PTR_W-1:0]         rp_r, rp_nxt;
  logic [shrm_pkg::FILL_W-1:0]        left_r, left_nxt;
  logic                               rd_pend_r, rd_pend_nxt;
  logic                               rd_last_r, rd_last_nxt;

  logic [shrm_pkg::FILL_W-1:0]        fill;
  logic [shrm_pkg::FILL_W-1:0]        fill_after;
  logic [shrm_pkg::FILL_W-1:0]        snap_len;
  logic [shrm_pkg::FILL_W-1:0]        back_sel;
  logic [shrm_pkg::FILL_W:0]          back_sum;
  logic [shrm_pkg::PTR_W-1:0]         back_addr;
  logic [shrm_pkg::OQ_CNT_W:0]        oq_load;
  logic                               room;
  logic                               read_ok;

  logic                               ram_we;
  logic                               ram_re;
  logic [shrm_pkg::PTR_W-1:0]         ram_raddr;
  logic [shrm_pkg::SAMP_W-1:0]        ram_rdata;

  logic signed [shrm_pkg::SAMP_W-1:0] res_val;
  logic                               res_has;
  logic                               res_last;

  shrm_ram #(
    .WIDTH (shrm_pkg::SAMP_W),
    .DEPTH (shrm_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (cmd.sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fill level and the slot a given distance behind the write pointer
  always_comb begin
    fill     = full_r ? shrm_pkg::FILL_W'(shrm_pkg::DEPTH) : shrm_pkg::FILL_W'(wp_r);
    snap_len = (cmd.cnt < fill) ? cmd.cnt : fill;
    read_ok  = cmd.age_ok && (cmd.cnt <= fill);
    back_sel = (cmd.op == shrm_pkg::OP_SNAP) ? snap_len : cmd.cnt;
    back_sum = (shrm_pkg::FILL_W + 1)'(wp_r) + (shrm_pkg::FILL_W + 1)'(shrm_pkg::DEPTH)
             - (shrm_pkg::FILL_W + 1)'(back_sel);
    if (back_sum >= (shrm_pkg::FILL_W + 1)'(shrm_pkg::DEPTH)) begin
      back_addr = shrm_pkg::PTR_W'(back_sum - (shrm_pkg::FILL_W + 1)'(shrm_pkg::DEPTH));
    end else begin
      back_addr = shrm_pkg::PTR_W'(back_sum);
    end
    oq_load = (shrm_pkg::OQ_CNT_W + 1)'(oq_count) + (shrm_pkg::OQ_CNT_W + 1)'(rd_pend_r);
    room    = (oq_load < (shrm_pkg::OQ_CNT_W + 1)'(shrm_pkg::OQ_DEPTH));
  end

  // Next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    full_nxt    = full_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    rp_nxt      = rp_r;
    left_nxt    = left_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    cmd_take    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rp_r;
    res_push    = 1'b0;
    res_val     = '0;
    res_has     = 1'b0;
    res_last    = 1'b1;

    // Deliver read data issued last cycle
    if (rd_pend_r) begin
      res_push = 1'b1;
      res_val  = ram_rdata;
      res_has  = 1'b1;
      res_last = rd_last_r;
    end

    unique case (state_r)
      shrm_pkg::BK_IDLE: begin
        if (cmd_valid && !rd_pend_r && room) begin
          cmd_take = 1'b1;
          unique case (cmd.op)
            shrm_pkg::OP_APPEND: begin
              ram_we   = 1'b1;
              if (cmd.sample > max_r) begin
                max_nxt = cmd.sample;
              end
              if (cmd.sample < min_r) begin
                min_nxt = cmd.sample;
              end
              if (wp_r == shrm_pkg::PTR_W'(shrm_pkg::DEPTH - 1)) begin
                wp_nxt   = '0;
                full_nxt = 1'b1;
              end else begin
                wp_nxt = wp_r + 1'b1;
              end
              res_push = 1'b1;
              res_val  = cmd.sample;
              res_has  = 1'b1;
            end
            shrm_pkg::OP_CLEAR: begin
              wp_nxt   = '0;
              full_nxt = 1'b0;
              min_nxt  = shrm_pkg::SAMP_MAX_POS;
              max_nxt  = shrm_pkg::SAMP_MAX_NEG;
              res_push = 1'b1;
            end
            shrm_pkg::OP_READ: begin
              if (read_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = back_addr;
                rd_pend_nxt = 1'b1;
                rd_last_nxt = 1'b1;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              // snapshot: empty result, or start the oldest-first sweep
              if (snap_len == '0) begin
                res_push = 1'b1;
              end else begin
                rp_nxt    = back_addr;
                left_nxt  = snap_len;
                state_nxt = shrm_pkg::BK_SNAP;
              end
            end
          endcase
        end
      end
      default: begin
        // Issue one store read per cycle while the result queue has room
        if (room) begin
          ram_re      = 1'b1;
          ram_raddr   = rp_r;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (left_r == shrm_pkg::FILL_W'(1));
          rp_nxt      = (rp_r == shrm_pkg::PTR_W'(shrm_pkg::DEPTH - 1)) ? '0 : rp_r + 1'b1;
          left_nxt    = left_r - 1'b1;
          if (left_r == shrm_pkg::FILL_W'(1)) begin
            state_nxt = shrm_pkg::BK_IDLE;
          end
        end
      end
    endcase
  end

  // Result carries the extremes and fill level after this command
  always_comb begin
    fill_after           = full_nxt ? shrm_pkg::FILL_W'(shrm_pkg::DEPTH)
                                    : shrm_pkg::FILL_W'(wp_nxt);
    res_data.value_out   = shrm_pkg::VAL_W'(res_val);
    res_data.has_sample  = res_has;
    res_data.is_last     = res_last;
    res_data.running_min = shrm_pkg::VAL_W'(min_nxt);
    res_data.running_max = shrm_pkg::VAL_W'(max_nxt);
    res_data.fill_count  = shrm_pkg::CNT_W'(fill_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= shrm_pkg::BK_IDLE;
      wp_r      <= '0;
      full_r    <= 1'b0;
      min_r     <= shrm_pkg::SAMP_MAX_POS;
      max_r     <= shrm_pkg::SAMP_MAX_NEG;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      full_r    <= full_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Sweep position and read tag need no reset
  always_ff @(posedge clk) begin
    rp_r      <= rp_nxt;
    left_r    <= left_nxt;
    rd_last_r <= rd_last_nxt;
  end

endmodule

### hw/rtl/sample_history_ring_minmax.sv
// Top level of the sample history recorder with running min and max.
//
// Input channel (in_push / in_full / in_data): one transaction per request:
// append a sample, snapshot the newest n samples, read by age, or clear.
// A two-entry command queue lets the front keep accepting while the back works.
// Result channel (out_empty / out_pop / out_data): a four-entry result queue.
// Append, clear and read-by-age give one result; a snapshot gives one result
// per returned sample, oldest first, with is_last on the final one (one empty
// result if none is returned). An append or clear result is registered into the
// result queue on acceptance; a read-by-age that hits the store first passes
// through the registered store read. Appends and clears sustain one per cycle
// while the result queue has room; after a read-by-age or a snapshot, the back
// takes no new command until the single store read port delivers its last read.
// Reset (rst_n low, synchronous) empties both queues, zeroes the write
// pointer and fill level and sets the extremes to their empty values.
// The store contents are not cleared. When the receiver stalls, the result
// queue fills, the back part pauses, and the command queue then asserts in_full.
module sample_history_ring_minmax (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  shrm_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output shrm_pkg::out_item_t out_data
);

  logic                          cmd_valid;
  logic                          cmd_take;
  shrm_pkg::cmd_t                cmd;
  logic [shrm_pkg::OQ_CNT_W-1:0] oq_count;
  logic                          res_push;
  shrm_pkg::out_item_t           res_data;

  shrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  shrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  shrm_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .oq_count  (oq_count),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/shrm_checker.sv
// Port-level checker for the sample history recorder, bound to the top level.
module shrm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input shrm_pkg::in_item_t  in_data,
  input logic                out_empty,
  input logic                out_pop,
  input shrm_pkg::out_item_t out_data
);

  // Result queue comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A result without a sample carries a zero value
  a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.has_sample) |-> (out_data.value_out == '0))
    else $error("result without sample has nonzero value");

  // Fill level never exceeds the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.fill_count <= shrm_pkg::CNT_W'(shrm_pkg::DEPTH)))
    else $error("fill count above store depth");

  // With samples held, min never exceeds max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.fill_count != '0)) |->
      (out_data.running_min <= out_data.running_max))
    else $error("running min above running max");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind sample_history_ring_minmax shrm_checker u_shrm_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the sample history ring with running min and max.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int CNT_TOP = (1 << shrm_pkg::CNT_W) - 1;

  localparam logic signed [shrm_pkg::VAL_W-1:0] TOP_Q    = 32'sh7FFF_FFFF;
  localparam logic signed [shrm_pkg::VAL_W-1:0] BOTTOM_Q = 32'sh8000_0000;
  localparam logic signed [shrm_pkg::VAL_W-1:0] EMPTY_LO = shrm_pkg::SAMP_MAX_POS;
  localparam logic signed [shrm_pkg::VAL_W-1:0] EMPTY_HI = shrm_pkg::SAMP_MAX_NEG;

  typedef enum int {DRAIN_STEADY, DRAIN_HALF, DRAIN_SPARSE} drain_mode_t;

  typedef struct {
    shrm_pkg::in_item_t  item;
    bit                  typed;
    shrm_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  shrm_pkg::in_item_t  in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  shrm_pkg::out_item_t out_data;

  logic      hold_req = 1'b0;
  int        n_errors = 0;
  int        burst_left = 0;

  // Shadow state of the recorder
  logic signed [shrm_pkg::VAL_W-1:0] hist_mem [shrm_pkg::DEPTH];
  logic [shrm_pkg::PTR_W-1:0]        wr_ptr;
  logic                              wrapped;
  logic signed [shrm_pkg::VAL_W-1:0] lo_seen;
  logic signed [shrm_pkg::VAL_W-1:0] hi_seen;

  shrm_pkg::out_item_t fresh_results[$];
  shrm_pkg::out_item_t awaited_results[$];
  dir_row_t            dir_rows[$];

  sample_history_ring_minmax i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_history();
    wr_ptr  = '0;
    wrapped = 1'b0;
    lo_seen = EMPTY_LO;
    hi_seen = EMPTY_HI;
  endfunction

  function automatic logic [shrm_pkg::CNT_W-1:0] fill_level();
    return wrapped ? shrm_pkg::CNT_W'(shrm_pkg::DEPTH) : shrm_pkg::CNT_W'(wr_ptr);
  endfunction

  // Tag a returned value with the current extremes and fill level
  function automatic shrm_pkg::out_item_t stamp(logic signed [shrm_pkg::VAL_W-1:0] v,
                                                logic has, logic last);
    shrm_pkg::out_item_t r;
    r.value_out   = v;
    r.has_sample  = has;
    r.is_last     = last;
    r.running_min = lo_seen;
    r.running_max = hi_seen;
    r.fill_count  = fill_level();
    return r;
  endfunction

  // Apply one request to the shadow state and collect the results it yields
  function automatic void predict_request(shrm_pkg::in_item_t it);
    logic signed [shrm_pkg::SAMP_W-1:0] narrow;
    logic signed [shrm_pkg::VAL_W-1:0]  v;
    int fill;
    int k;
    int age;
    int slot;
    int i;
    fresh_results.delete();
    fill = int'(fill_level());
    case (it.req_type)
      shrm_pkg::REQ_APPEND: begin
        narrow = it.sample_value[shrm_pkg::SAMP_W-1:0];
        v = narrow;
        hist_mem[wr_ptr] = v;
        if (v > hi_seen) hi_seen = v;
        if (v < lo_seen) lo_seen = v;
        wr_ptr = (int'(wr_ptr) == shrm_pkg::DEPTH - 1) ? '0 : wr_ptr + 1'b1;
        if (wr_ptr == '0) wrapped = 1'b1;
        fresh_results.push_back(stamp(v, 1'b1, 1'b1));
      end
      shrm_pkg::REQ_SNAP: begin
        k = (int'(it.count_or_age) < fill) ? int'(it.count_or_age) : fill;
        if (k == 0) fresh_results.push_back(stamp('0, 1'b0, 1'b1));
        for (i = 0; i < k; i++) begin
          slot = (int'(wr_ptr) + shrm_pkg::DEPTH - k + i) % shrm_pkg::DEPTH;
          fresh_results.push_back(stamp(hist_mem[slot], 1'b1, i == k - 1));
        end
      end
      shrm_pkg::REQ_READ: begin
        // age zero points at the write slot, which is the oldest one once full
        age = (it.count_or_age == '0) ? shrm_pkg::DEPTH : int'(it.count_or_age);
        if (int'(it.count_or_age) <= shrm_pkg::DEPTH && age <= fill) begin
          slot = (int'(wr_ptr) + shrm_pkg::DEPTH - age) % shrm_pkg::DEPTH;
          fresh_results.push_back(stamp(hist_mem[slot], 1'b1, 1'b1));
        end else begin
          fresh_results.push_back(stamp('0, 1'b0, 1'b1));
        end
      end
      default: begin
        clear_history();
        fresh_results.push_back(stamp('0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic shrm_pkg::in_item_t mk_req(logic [shrm_pkg::REQ_W-1:0] r,
                                                logic [shrm_pkg::VAL_W-1:0] v,
                                                logic [shrm_pkg::CNT_W-1:0] c);
    shrm_pkg::in_item_t it;
    it.req_type     = r;
    it.sample_value = v;
    it.count_or_age = c;
    return it;
  endfunction

  function automatic shrm_pkg::out_item_t mk_res(logic [shrm_pkg::VAL_W-1:0] v,
                                                 logic has, logic last,
                                                 logic [shrm_pkg::VAL_W-1:0] lo,
                                                 logic [shrm_pkg::VAL_W-1:0] hi,
                                                 logic [shrm_pkg::CNT_W-1:0] fill);
    shrm_pkg::out_item_t r;
    r.value_out   = v;
    r.has_sample  = has;
    r.is_last     = last;
    r.running_min = lo;
    r.running_max = hi;
    r.fill_count  = fill;
    return r;
  endfunction

  task automatic add_row(shrm_pkg::in_item_t it, bit typed, shrm_pkg::out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Pick a length or age: mostly inside the fill, some at and past the edges
  function automatic logic [shrm_pkg::CNT_W-1:0] pick_count(logic [shrm_pkg::REQ_W-1:0] r);
    int fill;
    int roll;
    fill = int'(fill_level());
    roll = $urandom_range(0, 11);
    if (roll == 0) return '0;
    if (roll == 1) return shrm_pkg::CNT_W'(shrm_pkg::DEPTH);
    if (roll == 2) return shrm_pkg::CNT_W'($urandom_range(shrm_pkg::DEPTH + 1, CNT_TOP));
    if (roll == 3) return shrm_pkg::CNT_W'($urandom);
    if (roll == 4 && fill < shrm_pkg::DEPTH) begin
      return shrm_pkg::CNT_W'($urandom_range(fill + 1, shrm_pkg::DEPTH));
    end
    if (fill == 0) return shrm_pkg::CNT_W'($urandom_range(1, 8));
    if (r == shrm_pkg::REQ_SNAP && fill > 8) return shrm_pkg::CNT_W'($urandom_range(1, 8));
    return shrm_pkg::CNT_W'($urandom_range(1, fill));
  endfunction

  function automatic shrm_pkg::in_item_t random_request(int append_pct, int clear_pct);
    logic [shrm_pkg::REQ_W-1:0] r;
    logic [shrm_pkg::VAL_W-1:0] v;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < append_pct) r = shrm_pkg::REQ_APPEND;
    else if (roll < append_pct + clear_pct) r = shrm_pkg::REQ_CLEAR;
    else if (roll % 2 == 0) r = shrm_pkg::REQ_SNAP;
    else r = shrm_pkg::REQ_READ;
    case ($urandom_range(0, 9))
      0: v = TOP_Q;
      1: v = BOTTOM_Q;
      2: v = '0;
      3: v = '1;
      4, 5: v = int'($urandom_range(0, 2000)) - 1000;
      default: v = $urandom;
    endcase
    return mk_req(r, v, pick_count(r));
  endfunction

  // Offer one transaction, book its results once taken, then pace the next one
  task automatic offer(shrm_pkg::in_item_t it, bit typed, shrm_pkg::out_item_t want);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    predict_request(it);
    if (typed) awaited_results.push_back(want);
    else foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic check_result(shrm_pkg::out_item_t got);
    shrm_pkg::out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: value_out %0d", got.value_out);
      n_errors++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.value_out !== want.value_out) begin
      $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
      n_errors++;
    end
    if (got.has_sample !== want.has_sample) begin
      $error("has_sample: expected %0b, got %0b", want.has_sample, got.has_sample);
      n_errors++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
      n_errors++;
    end
    if (got.running_min !== want.running_min) begin
      $error("running_min: expected %0d, got %0d", want.running_min, got.running_min);
      n_errors++;
    end
    if (got.running_max !== want.running_max) begin
      $error("running_max: expected %0d, got %0d", want.running_max, got.running_max);
      n_errors++;
    end
    if (got.fill_count !== want.fill_count) begin
      $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
      n_errors++;
    end
  endtask

  // Check every result transaction as it leaves the block
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_pop === 1'b1 && out_empty === 1'b0) check_result(out_data);
  end

  // Drain results in changing patterns, with one long hold-off on request
  initial begin : drain_pacing
    drain_mode_t mode;
    int mode_left;
    bit hold_done;
    mode = DRAIN_STEADY;
    mode_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = drain_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 48);
        end
        mode_left--;
        case (mode)
          DRAIN_STEADY: out_pop <= 1'b1;
          DRAIN_HALF:   out_pop <= 1'($urandom_range(0, 1));
          default:      out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stop a run that hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int i;
    clear_history();

    // Empty store, then the sample extremes, sizes at and past the fill, and a clear
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd5), 1'b1,
            mk_res('0, 1'b0, 1'b1, EMPTY_LO, EMPTY_HI, '0));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd1), 1'b1,
            mk_res('0, 1'b0, 1'b1, EMPTY_LO, EMPTY_HI, '0));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd0), 1'b1,
            mk_res('0, 1'b0, 1'b1, EMPTY_LO, EMPTY_HI, '0));
    add_row(mk_req(shrm_pkg::REQ_CLEAR, '1, 7'd127), 1'b1,
            mk_res('0, 1'b0, 1'b1, EMPTY_LO, EMPTY_HI, '0));
    add_row(mk_req(shrm_pkg::REQ_APPEND, TOP_Q, 7'd127), 1'b1,
            mk_res(TOP_Q, 1'b1, 1'b1, TOP_Q, TOP_Q, 7'd1));
    add_row(mk_req(shrm_pkg::REQ_APPEND, BOTTOM_Q, '0), 1'b1,
            mk_res(BOTTOM_Q, 1'b1, 1'b1, BOTTOM_Q, TOP_Q, 7'd2));
    add_row(mk_req(shrm_pkg::REQ_APPEND, '0, 7'd64), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_APPEND, 32'h1234_5678, 7'd3), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_APPEND, 32'hEDCB_A987, 7'd100), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_SNAP, '1, 7'd2), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd5), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd64), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd127), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd0), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd1), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd5), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd6), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd0), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd64), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd65), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_READ, '1, 7'd127), 1'b1,
            mk_res('0, 1'b0, 1'b1, BOTTOM_Q, TOP_Q, 7'd5));
    add_row(mk_req(shrm_pkg::REQ_CLEAR, '0, '0), 1'b1,
            mk_res('0, 1'b0, 1'b1, EMPTY_LO, EMPTY_HI, '0));
    add_row(mk_req(shrm_pkg::REQ_APPEND, '1, 7'd1), 1'b1,
            mk_res('1, 1'b1, 1'b1, '1, '1, 7'd1));
    add_row(mk_req(shrm_pkg::REQ_SNAP, '0, 7'd3), 1'b0, '0);
    add_row(mk_req(shrm_pkg::REQ_READ, '0, 7'd1), 1'b0, '0);

    // Hold reset, then release
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) offer(dir_rows[i].item, dir_rows[i].typed,
                                                  dir_rows[i].want);

    // Stall the result side for a while so the block backs up into in_full
    hold_req <= 1'b1;

    // Fill and wrap the store, with an occasional query in between
    repeat (70) offer(random_request(90, 0), 1'b0, '0);

    // Mixed traffic over a full and wrapping store, with rare clears
    repeat (65) offer(random_request(45, 5), 1'b0, '0);

    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
